// ===== hw/rtl/phd_pkg.sv =====
package phd_pkg;

	localparam int REG_W  = 5;
	localparam int NUM_W  = 10;
	localparam int FLOW_W = 2;
	localparam int CNT_W  = 24;

	localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
	localparam logic [CNT_W-1:0] CYC_RESET = CNT_W'(4);

	// instruction flow kinds; the unused code behaves as sequential
	localparam logic [FLOW_W-1:0] FLOW_SEQ    = 2'd0;
	localparam logic [FLOW_W-1:0] FLOW_BRANCH = 2'd1;
	localparam logic [FLOW_W-1:0] FLOW_JUMP   = 2'd2;

	// control hazard class of a judged instruction
	localparam logic [1:0] CTRL_NONE   = 2'd0;
	localparam logic [1:0] CTRL_BRANCH = 2'd1;
	localparam logic [1:0] CTRL_JUMP   = 2'd2;

	localparam logic KIND_CTRL = 1'b0;
	localparam logic KIND_DATA = 1'b1;

	localparam logic [1:0] REM_FLUSH3 = 2'd0;
	localparam logic [1:0] REM_FLUSH1 = 2'd1;
	localparam logic [1:0] REM_STALL  = 2'd2;
	localparam logic [1:0] REM_FWD    = 2'd3;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic              writes_reg;
		logic [REG_W-1:0]  dest_reg;
		logic              src_a_used;
		logic [REG_W-1:0]  src_a_reg;
		logic              src_b_used;
		logic [REG_W-1:0]  src_b_reg;
		logic              is_load;
		logic              is_store;
		logic [FLOW_W-1:0] flow_kind;
		logic [NUM_W-1:0]  instr_number;
	} entry_t;

	// one judged instruction, already classified
	typedef struct packed {
		logic             valid;
		logic [1:0]       ctrl;
		logic [NUM_W-1:0] e_num;
		logic             da;      // dependence on the next instruction
		logic [NUM_W-1:0] da_num;
		logic             load;
		logic             db;      // dependence on the second-next instruction
		logic [NUM_W-1:0] db_num;
	} judge_t;

	typedef struct packed {
		judge_t j1;
		judge_t j2;
		logic   last;
	} rec_t;

	typedef struct packed {
		logic [CNT_W-1:0] hazard_number;
		logic             hazard_kind;
		logic [NUM_W-1:0] victim_number;
		logic [CNT_W-1:0] clock_cycle;
		logic [1:0]       remedy;
		logic             last_in_run;
	} res_t;

endpackage

// ===== hw/rtl/phd_front.sv =====
module phd_front import phd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  entry_t in_item,
	input  logic   in_last,
	input  logic   q_full,
	output logic   push,
	output rec_t   push_rec
);

	entry_t     w0_q;
	entry_t     w1_q;
	logic [1:0] fill_q;
	logic       accept;
	entry_t     j2_e;

	function automatic logic reads(input entry_t f, input logic [REG_W-1:0] r);
		reads = (f.src_a_used && f.src_a_reg == r) || (f.src_b_used && f.src_b_reg == r);
	endfunction

	function automatic judge_t judge(input entry_t e, input entry_t f1, input entry_t f2,
			input logic has_f2, input logic vld);
		judge_t j;
		j.valid  = vld;
		j.ctrl   = CTRL_NONE;
		if (!e.writes_reg && !e.is_store) begin
			if (e.flow_kind == FLOW_BRANCH)
				j.ctrl = CTRL_BRANCH;
			else if (e.flow_kind == FLOW_JUMP)
				j.ctrl = CTRL_JUMP;
		end
		j.e_num  = e.instr_number;
		j.da     = e.writes_reg && reads(f1, e.dest_reg);
		j.da_num = f1.instr_number;
		j.load   = e.is_load;
		j.db     = has_f2 && e.writes_reg && reads(f2, e.dest_reg);
		j.db_num = f2.instr_number;
		judge    = j;
	endfunction

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// final pass judges the next-to-last item against the final one
	assign j2_e = (fill_q == 2'd2) ? w1_q : w0_q;

	always_comb begin
		push_rec.j1   = judge(w0_q, w1_q, in_item, 1'b1, fill_q == 2'd2);
		push_rec.j2   = judge(j2_e, in_item, in_item, 1'b0, in_last && fill_q != 2'd0);
		push_rec.last = in_last;
	end

	assign push = accept && (push_rec.j1.valid || push_rec.j2.valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else if (accept) begin
			if (in_last)
				fill_q <= 2'd0;
			else if (fill_q != 2'd2)
				fill_q <= fill_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (fill_q == 2'd2) begin
				w0_q <= w1_q;
				w1_q <= in_item;
			end else if (fill_q == 2'd1) begin
				w1_q <= in_item;
			end else begin
				w0_q <= in_item;
			end
		end
	end

endmodule

// ===== hw/rtl/phd_queue.sv =====
module phd_queue import phd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output rec_t head_rec
);

	rec_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = cnt_q == QCNT_W'(QDEPTH);
	assign head_valid = cnt_q != '0;
	assign head_rec   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_rec;
	end

endmodule

// ===== hw/rtl/phd_back.sv =====
module phd_back import phd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  rec_t head_rec,
	output logic pop,
	output logic out_valid,
	input  logic out_ready,
	output res_t out_res
);

	localparam logic [1:0] PH_START = 2'd0;
	localparam logic [1:0] PH_J1B   = 2'd1;
	localparam logic [1:0] PH_J2A   = 2'd2;

	logic [1:0]       phase_q;
	logic [CNT_W-1:0] cyc_q;
	logic [CNT_W-1:0] hz_q;
	logic             out_valid_q;
	res_t             out_q;

	logic             step;
	logic             use_j1;
	judge_t           j;
	logic             j2_hz;
	logic [CNT_W-1:0] c1;
	logic [CNT_W-1:0] c_next;
	logic [2:0]       extra;
	logic             emit;
	logic             done;
	logic [1:0]       phase_next;
	res_t             res;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
			input logic [2:0] b);
		logic [CNT_W:0] s;
		s = {1'b0, a} + (CNT_W + 1)'(b);
		sat_add = (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] sub_floor(input logic [CNT_W-1:0] a,
			input logic [1:0] k);
		sub_floor = (a > CNT_W'(k)) ? a - CNT_W'(k) : '0;
	endfunction

	assign step   = head_valid && (!out_valid_q || out_ready);
	assign use_j1 = phase_q == PH_START && head_rec.j1.valid;
	assign j      = use_j1 ? head_rec.j1 : head_rec.j2;
	assign j2_hz  = head_rec.j2.valid && (head_rec.j2.ctrl != CTRL_NONE || head_rec.j2.da);
	assign c1     = sat_add(cyc_q, 3'd1);

	always_comb begin
		case (j.ctrl)
			CTRL_BRANCH: extra = 3'd4;
			CTRL_JUMP:   extra = 3'd2;
			default:     extra = (j.da && j.load) ? 3'd2 : 3'd1;
		endcase
	end

	assign c_next = sat_add(cyc_q, extra);

	always_comb begin
		res.hazard_number = sat_add(hz_q, 3'd1);
		res.hazard_kind   = KIND_DATA;
		res.victim_number = j.da_num;
		res.clock_cycle   = sub_floor(c1, 2'd2);
		res.remedy        = j.load ? REM_STALL : REM_FWD;
		res.last_in_run   = 1'b1;
		emit              = 1'b0;
		done              = 1'b0;
		phase_next        = PH_START;
		case (phase_q)
			PH_J1B: begin
				emit              = 1'b1;
				res.victim_number = head_rec.j1.db_num;
				res.clock_cycle   = sub_floor(cyc_q, 2'd2);
				res.remedy        = REM_FWD;
				res.last_in_run   = !j2_hz;
				if (head_rec.j2.valid)
					phase_next = PH_J2A;
				else
					done = 1'b1;
			end
			default: begin
				if (j.ctrl == CTRL_BRANCH) begin
					emit              = 1'b1;
					res.hazard_kind   = KIND_CTRL;
					res.victim_number = j.e_num;
					res.clock_cycle   = sub_floor(c1, 2'd1);
					res.remedy        = REM_FLUSH3;
				end else if (j.ctrl == CTRL_JUMP) begin
					emit              = 1'b1;
					res.hazard_kind   = KIND_CTRL;
					res.victim_number = j.e_num;
					res.clock_cycle   = sub_floor(c1, 2'd3);
					res.remedy        = REM_FLUSH1;
				end else begin
					emit = j.da;
				end
				if (use_j1) begin
					res.last_in_run = !head_rec.j1.db && !j2_hz;
					if (head_rec.j1.db)
						phase_next = PH_J1B;
					else if (head_rec.j2.valid)
						phase_next = PH_J2A;
					else
						done = 1'b1;
				end else begin
					done = 1'b1;
				end
			end
		endcase
	end

	assign pop       = step && done;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_START;
			cyc_q       <= CYC_RESET;
			hz_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (step && emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (step) begin
				phase_q <= phase_next;
				if (done && head_rec.last) begin
					cyc_q <= CYC_RESET;
					hz_q  <= '0;
				end else begin
					if (phase_q != PH_J1B)
						cyc_q <= c_next;
					if (emit)
						hz_q <= res.hazard_number;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit)
			out_q <= res;
	end

`ifndef NO_ASSERTIONS
	a_busy_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_START |-> head_valid)
		else $error("mid-record phase with empty queue");

	a_kind_remedy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.hazard_kind == KIND_CTRL) |->
		(out_q.remedy == REM_FLUSH3 || out_q.remedy == REM_FLUSH1))
		else $error("control hazard with a forwarding remedy");

	a_cycle_floor: assert property (@(posedge clk) disable iff (!arst_n)
		cyc_q >= CYC_RESET)
		else $error("cycle counter below its reset value");

	a_reset_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_rec.last) |=> (hz_q == '0 && cyc_q == CYC_RESET))
		else $error("counters not cleared after final record");
`endif

endmodule

// ===== hw/rtl/pipeline_hazard_detector_unit.sv =====
// Hazard detector for a five-stage pipeline, fed with an executed-instruction trace.
// Input stream (s_*): one request per executed instruction; s_tlast marks the
// final instruction of the trace, after which the window and both counters restart.
// Output stream (m_*): one request per detected hazard; m_tlast flags the last
// hazard caused by a given input request. An input may cause none, one, two or
// (on the final instruction) three hazards.
// Classification happens in the cycle the input is taken; records then pass a
// two-deep queue to the reporting sequencer, which takes one judged instruction
// per step, plus an extra step for a second-next dependence. While the queue has
// room, new inputs are taken while the sequencer still reports earlier records.
// From input to first output a record passes the queue, then the output register.
// A stalled m_tready holds the output register; the queue then fills and
// s_tready drops, so nothing is lost. Reset is asynchronous and empties the
// window, the queue and the output register, and sets the cycle counter to 4.
module pipeline_hazard_detector_unit import phd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// writes_reg, dest_reg, src_a_used, src_a_reg, src_b_used, src_b_reg,
	// is_load, is_store, instr_number, zero pad
	input  logic [31:0] s_tdata,
	input  logic [1:0]  s_tuser,  // flow_kind
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	// hazard_number, victim_number, clock_cycle, remedy, zero pad
	output logic [63:0] m_tdata,
	output logic        m_tuser,  // hazard_kind
	output logic        m_tlast
);

	entry_t item;
	logic   q_full;
	logic   push;
	rec_t   push_rec;
	logic   pop;
	logic   head_valid;
	rec_t   head_rec;
	res_t   res;

	always_comb begin
		item.writes_reg   = s_tdata[0];
		item.dest_reg     = s_tdata[5:1];
		item.src_a_used   = s_tdata[6];
		item.src_a_reg    = s_tdata[11:7];
		item.src_b_used   = s_tdata[12];
		item.src_b_reg    = s_tdata[17:13];
		item.is_load      = s_tdata[18];
		item.is_store     = s_tdata[19];
		item.instr_number = s_tdata[29:20];
		item.flow_kind    = s_tuser;
	end

	phd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (item),
		.in_last  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.push_rec (push_rec)
	);

	phd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_rec   (head_rec)
	);

	phd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_res    (res)
	);

	assign m_tdata = {4'b0, res.remedy, res.clock_cycle, res.victim_number, res.hazard_number};
	assign m_tuser = res.hazard_kind;
	assign m_tlast = res.last_in_run;

endmodule
